[rtl/msie_pkg.sv]
package msie_pkg;

    localparam int TEXT_DEPTH_DEF = 1024;
    localparam int DATA_DEPTH_DEF = 256;
    localparam int REG_COUNT = 32;
    localparam int RA_W = 5;
    localparam int PC_W = 11;
    localparam int NXT_W = 27;
    localparam int MD_STEPS = 32;
    localparam int MD_CW = 5;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_PRINT    = 4'd1;
    localparam logic [3:0] ST_EXIT     = 4'd2;
    localparam logic [3:0] ST_FINISHED = 4'd3;
    localparam logic [3:0] ST_BADINSTR = 4'd4;
    localparam logic [3:0] ST_MEMRANGE = 4'd5;
    localparam logic [3:0] ST_DIVZERO  = 4'd6;
    localparam logic [3:0] ST_PCRANGE  = 4'd7;
    localparam logic [3:0] ST_HALTED   = 4'd8;

    localparam logic [5:0] OPC_SPECIAL = 6'd0;
    localparam logic [5:0] OPC_J       = 6'd2;
    localparam logic [5:0] OPC_BEQ     = 6'd4;
    localparam logic [5:0] OPC_BNE     = 6'd5;
    localparam logic [5:0] OPC_ADDIU   = 6'd9;
    localparam logic [5:0] OPC_LW      = 6'd35;
    localparam logic [5:0] OPC_SW      = 6'd43;

    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_ADDU    = 6'd33;
    localparam logic [5:0] FN_SUBU    = 6'd35;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_SLT     = 6'd42;

    localparam logic [RA_W-1:0] REG_V0 = 5'd2;
    localparam logic [RA_W-1:0] REG_A0 = 5'd4;
    localparam logic [RA_W-1:0] REG_GP = 5'd28;

    localparam logic [31:0] SYS_PRINT = 32'd1;
    localparam logic [31:0] SYS_READ  = 32'd5;
    localparam logic [31:0] SYS_EXIT  = 32'd10;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

endpackage

[rtl/msie_muldiv.sv]
module msie_muldiv (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  msie_pkg::md_req_t      req,
    input  logic [31:0]            op_a,
    input  logic [31:0]            op_b,
    output logic                   done,
    output logic [31:0]            hi,
    output logic [31:0]            lo
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_RUN  = 2'd1;
    localparam logic [1:0] M_FIX  = 2'd2;

    logic [1:0]                 state_reg;
    logic [msie_pkg::MD_CW-1:0] cnt_reg;
    logic                       div_reg;
    logic                       neg_q_reg;
    logic                       neg_r_reg;
    logic [31:0]                hi_reg;
    logic [31:0]                lo_reg;
    logic [31:0]                mb_reg;
    logic                       done_reg;
    logic [32:0]                add_a;
    logic [32:0]                add_b;
    logic [33:0]                sum;
    logic [63:0]                prod_neg;

    always_comb begin
        if (div_reg) begin
            add_a = {hi_reg, lo_reg[31]};
            add_b = ~{1'b0, mb_reg};
        end else begin
            add_a = {1'b0, hi_reg};
            add_b = lo_reg[0] ? {1'b0, mb_reg} : 33'd0;
        end
        sum = {1'b0, add_a} + {1'b0, add_b} + {33'd0, div_reg};
        prod_neg = -{hi_reg, lo_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE: begin
                    if (req.start) begin
                        div_reg   <= req.is_div;
                        neg_q_reg <= op_a[31] ^ op_b[31];
                        neg_r_reg <= op_a[31];
                        hi_reg    <= 32'd0;
                        lo_reg    <= op_a[31] ? -op_a : op_a;
                        mb_reg    <= op_b[31] ? -op_b : op_b;
                        cnt_reg   <= '0;
                        state_reg <= M_RUN;
                    end
                end
                M_RUN: begin
                    if (div_reg) begin
                        if (sum[33]) begin
                            hi_reg <= sum[31:0];
                            lo_reg <= {lo_reg[30:0], 1'b1};
                        end else begin
                            hi_reg <= add_a[31:0];
                            lo_reg <= {lo_reg[30:0], 1'b0};
                        end
                    end else begin
                        hi_reg <= sum[32:1];
                        lo_reg <= {sum[0], lo_reg[31:1]};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == msie_pkg::MD_CW'(msie_pkg::MD_STEPS - 1)) begin
                        state_reg <= M_FIX;
                    end
                end
                M_FIX: begin
                    if (div_reg) begin
                        if (neg_q_reg) begin
                            lo_reg <= -lo_reg;
                        end
                        if (neg_r_reg) begin
                            hi_reg <= -hi_reg;
                        end
                    end else if (neg_q_reg) begin
                        {hi_reg, lo_reg} <= prod_neg;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign hi   = hi_reg;
    assign lo   = lo_reg;

endmodule

[rtl/mips_subset_instruction_executor_core.sv]
// Executes one instruction of a small MIPS subset per input transaction.
// The input channel (s_) carries either an instruction word for the current
// program counter or, with s_op high, a preload of one data memory word.
// Every input transaction produces exactly one result transaction on the m_
// channel with a status code, the next program counter and a print value.
// Two registers on the APB port set the program length and the number of
// valid data words; writing the program length also loads the global pointer.
// A load passes through an extra state for the registered data memory read.
// Multiply and divide run on a shared add-and-shift unit that needs 32 steps
// plus a sign fix.
// Preloads and transactions answered while halted skip the read and execute states.
// Reset clears the register file, hi, lo, the program counter and the halt
// flag; the data memory holds its contents until written.
// The result waits in an output register while m_ready is low, and the next
// input transaction may already be accepted; it finishes only once that
// register is free.
module mips_subset_instruction_executor_core #(
    parameter int TEXT_DEPTH = msie_pkg::TEXT_DEPTH_DEF,
    parameter int DATA_DEPTH = msie_pkg::DATA_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [31:0]        s_instruction,
    input  logic [7:0]         s_data_index,
    input  logic signed [31:0] s_data_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_status,
    output logic [9:0]         m_next_pc,
    output logic signed [31:0] m_print_value
);

    localparam int MEM_DEPTH = (DATA_DEPTH < 512) ? DATA_DEPTH : 512;
    localparam int MEM_AW = $clog2(MEM_DEPTH);
    localparam int RA_W = msie_pkg::RA_W;
    localparam int PC_W = msie_pkg::PC_W;
    localparam int NXT_W = msie_pkg::NXT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EX   = 3'd2;
    localparam logic [2:0] S_MD   = 3'd3;
    localparam logic [2:0] S_LD   = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [PC_W-1:0]         pc_reg;
    logic                    halt_reg;
    logic [10:0]             tw_reg;
    logic [8:0]              dw_reg;
    logic [31:0]             hi_reg;
    logic [31:0]             lo_reg;
    logic [31:0]             ins_reg;
    logic [31:0]             dval_reg;
    logic [3:0]              st_reg;
    logic signed [NXT_W-1:0] nxt_reg;
    logic [31:0]             pv_reg;
    logic                    raw_reg;
    logic [RA_W-1:0]         ld_ra_reg;
    logic                    m_valid_reg;
    logic [3:0]              m_status_reg;
    logic [9:0]              m_pc_reg;
    logic [31:0]             m_pv_reg;

    logic [31:0]             rf_mem [msie_pkg::REG_COUNT];
    logic [msie_pkg::REG_COUNT-1:0] rf_vld_reg;
    logic [31:0]             rf_qa_reg;
    logic [31:0]             rf_qb_reg;
    logic                    rf_va_reg;
    logic                    rf_vb_reg;
    logic [31:0]             dm_mem [MEM_DEPTH];
    logic [31:0]             dm_q_reg;

    logic [PC_W-1:0]         limit;
    logic                    accept;
    logic                    cfg_wr;
    logic                    out_free;
    logic [5:0]              opc;
    logic [5:0]              fn;
    logic [RA_W-1:0]         rs;
    logic [RA_W-1:0]         rt;
    logic [RA_W-1:0]         rd;
    logic [15:0]             imm;
    logic                    is_sys;
    logic [RA_W-1:0]         ra_a;
    logic [RA_W-1:0]         ra_b;
    logic [31:0]             a;
    logic [31:0]             b;

    logic [3:0]              ex_st;
    logic signed [NXT_W-1:0] ex_next;
    logic                    ex_we;
    logic [RA_W-1:0]         ex_wa;
    logic [31:0]             ex_wd;
    logic                    ex_md;
    logic                    ex_ld;
    logic                    ex_sw;
    logic                    mem_bad;
    logic [MEM_AW-1:0]       mem_idx;

    logic                    rf_we;
    logic [RA_W-1:0]         rf_wa;
    logic [31:0]             rf_wd;
    logic                    dm_we;
    logic [MEM_AW-1:0]       dm_wa;
    logic [31:0]             dm_wd;

    msie_pkg::md_req_t       md_req;
    logic                    md_done;
    logic [31:0]             md_hi;
    logic [31:0]             md_lo;

    logic                    fin_fault;
    logic                    fin_range;
    logic [3:0]              fin_st;
    logic [9:0]              fin_pc;
    logic [31:0]             fin_pv;
    logic                    fin_halt;
    logic                    fin_adv;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {23'd0, dw_reg} : {21'd0, tw_reg};
    assign cfg_wr = psel && penable && pwrite;

    assign limit = (32'(tw_reg) < 32'(TEXT_DEPTH)) ? tw_reg : PC_W'(TEXT_DEPTH);
    assign s_ready = (state_reg == S_IDLE);
    assign accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign opc = ins_reg[31:26];
    assign fn = ins_reg[5:0];
    assign rs = ins_reg[25:21];
    assign rt = ins_reg[20:16];
    assign rd = ins_reg[15:11];
    assign imm = ins_reg[15:0];
    assign is_sys = (opc == msie_pkg::OPC_SPECIAL) && (fn == msie_pkg::FN_SYSCALL);
    assign ra_a = is_sys ? msie_pkg::REG_V0 : rs;
    assign ra_b = is_sys ? msie_pkg::REG_A0 : rt;
    assign a = rf_va_reg ? rf_qa_reg : 32'd0;
    assign b = rf_vb_reg ? rf_qb_reg : 32'd0;

    assign mem_bad = imm[15] || ({1'b0, imm[14:0]} >= {7'd0, dw_reg})
                     || (32'(imm[14:0]) >= 32'(DATA_DEPTH));
    assign mem_idx = MEM_AW'(imm[14:0]);

    always_comb begin
        ex_st = msie_pkg::ST_OK;
        ex_next = $signed({{(NXT_W-PC_W){1'b0}}, pc_reg}) + NXT_W'(1);
        ex_we = 1'b0;
        ex_wa = rd;
        ex_wd = 32'd0;
        ex_md = 1'b0;
        ex_ld = 1'b0;
        ex_sw = 1'b0;
        unique case (opc) inside
            msie_pkg::OPC_SPECIAL: begin
                unique case (fn)
                    msie_pkg::FN_ADDU: begin
                        ex_we = 1'b1;
                        ex_wd = a + b;
                    end
                    msie_pkg::FN_SUBU: begin
                        ex_we = 1'b1;
                        ex_wd = a - b;
                    end
                    msie_pkg::FN_AND: begin
                        ex_we = 1'b1;
                        ex_wd = a & b;
                    end
                    msie_pkg::FN_OR: begin
                        ex_we = 1'b1;
                        ex_wd = a | b;
                    end
                    msie_pkg::FN_SLT: begin
                        ex_we = 1'b1;
                        ex_wd = {31'd0, $signed(a) < $signed(b)};
                    end
                    msie_pkg::FN_MULT: begin
                        ex_md = 1'b1;
                    end
                    msie_pkg::FN_DIV: begin
                        if (b == 32'd0) begin
                            ex_st = msie_pkg::ST_DIVZERO;
                        end else begin
                            ex_md = 1'b1;
                        end
                    end
                    msie_pkg::FN_MFHI: begin
                        ex_we = 1'b1;
                        ex_wd = hi_reg;
                    end
                    msie_pkg::FN_MFLO: begin
                        ex_we = 1'b1;
                        ex_wd = lo_reg;
                    end
                    msie_pkg::FN_SYSCALL: begin
                        if (a == msie_pkg::SYS_PRINT) begin
                            ex_st = msie_pkg::ST_PRINT;
                        end else if (a == msie_pkg::SYS_READ) begin
                            ex_we = 1'b1;
                            ex_wa = msie_pkg::REG_V0;
                            ex_wd = dval_reg;
                        end else if (a == msie_pkg::SYS_EXIT) begin
                            ex_st = msie_pkg::ST_EXIT;
                        end
                    end
                    default: begin
                        ex_st = msie_pkg::ST_BADINSTR;
                    end
                endcase
            end
            msie_pkg::OPC_ADDIU: begin
                ex_we = 1'b1;
                ex_wa = rt;
                ex_wd = a + {{16{imm[15]}}, imm};
            end
            msie_pkg::OPC_BEQ, msie_pkg::OPC_BNE: begin
                if ((a == b) == (opc == msie_pkg::OPC_BEQ)) begin
                    ex_next = $signed({{(NXT_W-PC_W){1'b0}}, pc_reg})
                              + $signed({{(NXT_W-16){imm[15]}}, imm});
                end
            end
            msie_pkg::OPC_LW: begin
                if (mem_bad) begin
                    ex_st = msie_pkg::ST_MEMRANGE;
                end else begin
                    ex_ld = 1'b1;
                end
            end
            msie_pkg::OPC_SW: begin
                if (mem_bad) begin
                    ex_st = msie_pkg::ST_MEMRANGE;
                end else begin
                    ex_sw = 1'b1;
                end
            end
            msie_pkg::OPC_J: begin
                ex_next = $signed({1'b0, ins_reg[25:0]});
            end
            default: begin
                ex_st = msie_pkg::ST_BADINSTR;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_op || halt_reg || (pc_reg >= limit)) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                state_next = S_EX;
            end
            S_EX: begin
                if (ex_md) begin
                    state_next = S_MD;
                end else if (ex_ld) begin
                    state_next = S_LD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_MD: begin
                if (md_done) begin
                    state_next = S_FIN;
                end
            end
            S_LD: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign md_req.start = (state_reg == S_EX) && ex_md;
    assign md_req.is_div = (fn == msie_pkg::FN_DIV);

    msie_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .op_a    (a),
        .op_b    (b),
        .done    (md_done),
        .hi      (md_hi),
        .lo      (md_lo)
    );

    always_comb begin
        rf_we = 1'b0;
        rf_wa = ex_wa;
        rf_wd = ex_wd;
        if (cfg_wr && !paddr[2]) begin
            rf_we = 1'b1;
            rf_wa = msie_pkg::REG_GP;
            rf_wd = {21'd0, pwdata[10:0]};
        end else if (state_reg == S_EX) begin
            rf_we = ex_we;
        end else if (state_reg == S_LD) begin
            rf_we = 1'b1;
            rf_wa = ld_ra_reg;
            rf_wd = dm_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_wa] <= rf_wd;
        end
        rf_qa_reg <= rf_mem[ra_a];
        rf_qb_reg <= rf_mem[ra_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_vld_reg <= '0;
            rf_va_reg  <= 1'b0;
            rf_vb_reg  <= 1'b0;
        end else begin
            if (rf_we && (rf_wa != '0)) begin
                rf_vld_reg[rf_wa] <= 1'b1;
            end
            rf_va_reg <= rf_vld_reg[ra_a];
            rf_vb_reg <= rf_vld_reg[ra_b];
        end
    end

    always_comb begin
        dm_we = 1'b0;
        dm_wa = mem_idx;
        dm_wd = b;
        if (accept && s_op) begin
            dm_we = (32'(s_data_index) < 32'(DATA_DEPTH));
            dm_wa = MEM_AW'(s_data_index);
            dm_wd = s_data_value;
        end else if (state_reg == S_EX) begin
            dm_we = ex_sw;
        end
    end

    always_ff @(posedge aclk) begin
        if (dm_we) begin
            dm_mem[dm_wa] <= dm_wd;
        end
        dm_q_reg <= dm_mem[mem_idx];
    end

    assign fin_fault = (st_reg == msie_pkg::ST_BADINSTR) || (st_reg == msie_pkg::ST_MEMRANGE)
                       || (st_reg == msie_pkg::ST_DIVZERO) || (st_reg == msie_pkg::ST_EXIT);
    assign fin_range = (nxt_reg < 0)
                       || (nxt_reg > $signed({{(NXT_W-PC_W){1'b0}}, limit}));

    always_comb begin
        fin_st = st_reg;
        fin_pc = pc_reg[9:0];
        fin_pv = 32'd0;
        fin_halt = 1'b0;
        fin_adv = 1'b0;
        if (raw_reg) begin
            fin_halt = (st_reg == msie_pkg::ST_PCRANGE);
        end else if (fin_fault) begin
            fin_halt = 1'b1;
        end else if (fin_range) begin
            fin_halt = 1'b1;
            fin_st = msie_pkg::ST_PCRANGE;
        end else begin
            fin_adv = 1'b1;
            fin_pc = nxt_reg[9:0];
            fin_pv = pv_reg;
            if (nxt_reg == $signed({{(NXT_W-PC_W){1'b0}}, limit})) begin
                fin_halt = 1'b1;
                if (st_reg != msie_pkg::ST_PRINT) begin
                    fin_st = msie_pkg::ST_FINISHED;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            halt_reg    <= 1'b0;
            tw_reg      <= '0;
            dw_reg      <= '0;
            hi_reg      <= '0;
            lo_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                if (paddr[2]) begin
                    dw_reg <= pwdata[8:0];
                end else begin
                    tw_reg <= pwdata[10:0];
                end
            end
            if (m_valid_reg && m_ready && (state_reg != S_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        ins_reg  <= s_instruction;
                        dval_reg <= s_data_value;
                        pv_reg   <= 32'd0;
                        raw_reg  <= s_op || halt_reg || (pc_reg >= limit);
                        if (s_op) begin
                            st_reg <= msie_pkg::ST_OK;
                        end else if (halt_reg) begin
                            st_reg <= msie_pkg::ST_HALTED;
                        end else if (pc_reg >= limit) begin
                            st_reg <= msie_pkg::ST_PCRANGE;
                        end
                    end
                end
                S_RD: begin
                end
                S_EX: begin
                    st_reg    <= ex_st;
                    nxt_reg   <= ex_next;
                    ld_ra_reg <= rt;
                    if (ex_st == msie_pkg::ST_PRINT) begin
                        pv_reg <= b;
                    end
                end
                S_MD: begin
                    if (md_done) begin
                        hi_reg <= md_hi;
                        lo_reg <= md_lo;
                    end
                end
                S_LD: begin
                end
                S_FIN: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_pc_reg     <= fin_pc;
                        m_pv_reg     <= fin_pv;
                        m_status_reg <= fin_st;
                        if (fin_halt) begin
                            halt_reg <= 1'b1;
                        end
                        if (fin_adv) begin
                            pc_reg <= nxt_reg[PC_W-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_next_pc = m_pc_reg;
    assign m_print_value = m_pv_reg;

endmodule

[tb/msie_tb_pkg.sv]
`timescale 1ns / 1ps
package msie_tb_pkg;

    localparam logic [2:0] ADDR_TEXT_WORDS = 3'd0;
    localparam logic [2:0] ADDR_DATA_WORDS = 3'd4;

endpackage

[tb/msie_checker.sv]
`timescale 1ns / 1ps
module msie_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_op,
    input  logic [31:0]        s_instruction,
    input  logic [7:0]         s_data_index,
    input  logic signed [31:0] s_data_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [3:0]         m_status,
    input  logic [9:0]         m_next_pc,
    input  logic signed [31:0] m_print_value,
    output int                 fail_count,
    output int                 pending,
    output int                 checked
);

    typedef struct packed {
        logic [3:0]  status;
        logic [9:0]  next_pc;
        logic [31:0] print_value;
    } outcome_t;

    outcome_t    awaited[$];
    logic [31:0] gpr[msie_pkg::REG_COUNT];
    logic [31:0] hi_q;
    logic [31:0] lo_q;
    logic [31:0] dmem[msie_pkg::DATA_DEPTH_DEF];
    logic [10:0] pc_q;
    logic        halted_q;
    logic [10:0] text_words_q;
    logic [8:0]  data_words_q;

    initial begin
        fail_count = 0;
        pending = 0;
        checked = 0;
    end

    function automatic logic [31:0] read_gpr(input logic [4:0] r);
        return (r == 5'd0) ? 32'd0 : gpr[r];
    endfunction

    function automatic void write_gpr(input logic [4:0] r, input logic [31:0] v);
        if (r != 5'd0) begin
            gpr[r] = v;
        end
    endfunction

    function automatic outcome_t run_item(input logic op, input logic [31:0] ins,
                                          input logic [7:0] idx, input logic [31:0] dv);
        outcome_t    r;
        logic [5:0]  opc;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [31:0] a;
        logic [31:0] b;
        longint      imm;
        longint      x;
        longint      y;
        longint      prod;
        longint      nxt;
        longint      lim;
        logic [3:0]  st;
        logic [31:0] pv;
        r = '0;
        r.next_pc = pc_q[9:0];
        lim = (text_words_q < msie_pkg::TEXT_DEPTH_DEF) ? longint'(text_words_q)
                                                         : msie_pkg::TEXT_DEPTH_DEF;
        if (op) begin
            dmem[idx] = dv;
            return r;
        end
        if (halted_q) begin
            r.status = msie_pkg::ST_HALTED;
            return r;
        end
        if (longint'(pc_q) >= lim) begin
            halted_q = 1'b1;
            r.status = msie_pkg::ST_PCRANGE;
            return r;
        end
        opc = ins[31:26];
        rs = ins[25:21];
        rt = ins[20:16];
        rd = ins[15:11];
        fn = ins[5:0];
        imm = longint'($signed(ins[15:0]));
        a = read_gpr(rs);
        b = read_gpr(rt);
        x = longint'($signed(a));
        y = longint'($signed(b));
        nxt = longint'(pc_q) + 1;
        st = msie_pkg::ST_OK;
        pv = 32'd0;
        if (opc == msie_pkg::OPC_SPECIAL) begin
            case (fn)
                msie_pkg::FN_ADDU: write_gpr(rd, a + b);
                msie_pkg::FN_SUBU: write_gpr(rd, a - b);
                msie_pkg::FN_AND:  write_gpr(rd, a & b);
                msie_pkg::FN_OR:   write_gpr(rd, a | b);
                msie_pkg::FN_SLT:  write_gpr(rd, (x < y) ? 32'd1 : 32'd0);
                msie_pkg::FN_MULT: begin
                    prod = x * y;
                    hi_q = prod[63:32];
                    lo_q = prod[31:0];
                end
                msie_pkg::FN_DIV: begin
                    if (y == 0) begin
                        st = msie_pkg::ST_DIVZERO;
                    end else begin
                        prod = x / y;
                        lo_q = prod[31:0];
                        prod = x % y;
                        hi_q = prod[31:0];
                    end
                end
                msie_pkg::FN_MFHI: write_gpr(rd, hi_q);
                msie_pkg::FN_MFLO: write_gpr(rd, lo_q);
                msie_pkg::FN_SYSCALL: begin
                    if (read_gpr(msie_pkg::REG_V0) == msie_pkg::SYS_PRINT) begin
                        st = msie_pkg::ST_PRINT;
                        pv = read_gpr(msie_pkg::REG_A0);
                    end else if (read_gpr(msie_pkg::REG_V0) == msie_pkg::SYS_READ) begin
                        write_gpr(msie_pkg::REG_V0, dv);
                    end else if (read_gpr(msie_pkg::REG_V0) == msie_pkg::SYS_EXIT) begin
                        st = msie_pkg::ST_EXIT;
                    end
                end
                default: st = msie_pkg::ST_BADINSTR;
            endcase
        end else begin
            case (opc) inside
                msie_pkg::OPC_ADDIU: write_gpr(rt, a + imm[31:0]);
                msie_pkg::OPC_BEQ: if (a == b) nxt = longint'(pc_q) + imm;
                msie_pkg::OPC_BNE: if (a != b) nxt = longint'(pc_q) + imm;
                msie_pkg::OPC_LW, msie_pkg::OPC_SW: begin
                    if (imm < 0 || imm >= longint'(data_words_q)
                        || imm >= msie_pkg::DATA_DEPTH_DEF) begin
                        st = msie_pkg::ST_MEMRANGE;
                    end else if (opc == msie_pkg::OPC_LW) begin
                        write_gpr(rt, dmem[imm[7:0]]);
                    end else begin
                        dmem[imm[7:0]] = b;
                    end
                end
                msie_pkg::OPC_J: nxt = longint'(ins[25:0]);
                default: st = msie_pkg::ST_BADINSTR;
            endcase
        end
        if (st == msie_pkg::ST_BADINSTR || st == msie_pkg::ST_MEMRANGE
            || st == msie_pkg::ST_DIVZERO || st == msie_pkg::ST_EXIT) begin
            halted_q = 1'b1;
            r.status = st;
            return r;
        end
        if (nxt < 0 || nxt > lim) begin
            halted_q = 1'b1;
            r.status = msie_pkg::ST_PCRANGE;
            return r;
        end
        pc_q = nxt[10:0];
        if (nxt == lim) begin
            halted_q = 1'b1;
            if (st != msie_pkg::ST_PRINT) begin
                st = msie_pkg::ST_FINISHED;
            end
        end
        r.status = st;
        r.next_pc = pc_q[9:0];
        r.print_value = pv;
        return r;
    endfunction

    always @(posedge aclk) begin
        outcome_t e;
        if (!aresetn) begin
            for (int i = 0; i < msie_pkg::REG_COUNT; i++) begin
                gpr[i] = 32'd0;
            end
            hi_q = 32'd0;
            lo_q = 32'd0;
            pc_q = '0;
            halted_q = 1'b0;
            text_words_q = '0;
            data_words_q = '0;
            awaited.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == msie_tb_pkg::ADDR_TEXT_WORDS) begin
                    text_words_q = pwdata[10:0];
                    gpr[msie_pkg::REG_GP] = {21'd0, pwdata[10:0]};
                end else if (paddr == msie_tb_pkg::ADDR_DATA_WORDS) begin
                    data_words_q = pwdata[8:0];
                end
            end
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    $error("Unexpected result transaction: status %0d next_pc %0d",
                           m_status, m_next_pc);
                    fail_count++;
                end else begin
                    e = awaited.pop_front();
                    checked++;
                    if (m_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, m_status);
                        fail_count++;
                    end
                    if (m_next_pc !== e.next_pc) begin
                        $error("next_pc: expected %0d, got %0d", e.next_pc, m_next_pc);
                        fail_count++;
                    end
                    if (m_print_value !== e.print_value) begin
                        $error("print_value: expected %0d, got %0d",
                               $signed(e.print_value), m_print_value);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited.insert(awaited.size(),
                               run_item(s_op, s_instruction, s_data_index, s_data_value));
            end
        end
        pending = awaited.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

    localparam logic [5:0] OPC_UNUSED = 6'd63;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_op = 1'b0;
    logic [31:0]        s_instruction = '0;
    logic [7:0]         s_data_index = '0;
    logic signed [31:0] s_data_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [3:0]         m_status;
    logic [9:0]         m_next_pc;
    logic signed [31:0] m_print_value;

    int fail_count;
    int pending;
    int checked;
    int idle_pct = 0;
    int stall_pct = 0;
    int pc_sh = 0;
    int tw_sh = 0;
    int dw_sh = 0;
    int n_items = 0;
    int n_preloads = 0;
    int scenario;
    bit written[256];

    mips_subset_instruction_executor_core i_dut (.*);

    msie_checker i_chk (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        #10ms;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic logic [31:0] rtype(input logic [5:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd);
        return {msie_pkg::OPC_SPECIAL, rs, rt, rd, 5'($urandom), fn};
    endfunction

    function automatic logic [31:0] itype(input logic [5:0] opc, input logic [4:0] rs,
                                          input logic [4:0] rt, input int imm);
        return {opc, rs, rt, imm[15:0]};
    endfunction

    function automatic logic [4:0] free_reg();
        logic [4:0] r;
        do begin
            r = 5'($urandom);
        end while (r == msie_pkg::REG_V0 || r == msie_pkg::REG_GP || r == 5'd30);
        return r;
    endfunction

    task automatic put_item(input logic op, input logic [31:0] ins, input logic [7:0] idx,
                            input logic [31:0] dv);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_instruction <= ins;
        s_data_index <= idx;
        s_data_value <= dv;
        do @(posedge aclk); while (!s_ready);
        n_items++;
    endtask

    task automatic exec(input logic [31:0] ins, input logic [31:0] dv = $urandom);
        put_item(1'b0, ins, 8'($urandom), dv);
        if (ins[31:26] == msie_pkg::OPC_J) begin
            pc_sh = int'(ins[25:0]);
        end else if (ins[31:26] == msie_pkg::OPC_BEQ && ins[25:21] == ins[20:16]) begin
            pc_sh = pc_sh + int'($signed(ins[15:0]));
        end else begin
            pc_sh = pc_sh + 1;
        end
        if (ins[31:26] == msie_pkg::OPC_SW) begin
            written[ins[7:0]] = 1'b1;
        end
    endtask

    task automatic preload(input logic [7:0] idx, input logic [31:0] val);
        put_item(1'b1, $urandom, idx, val);
        written[idx] = 1'b1;
        n_preloads++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == msie_tb_pkg::ADDR_TEXT_WORDS) begin
            tw_sh = int'(data[10:0]);
        end else begin
            dw_sh = int'(data[8:0]);
        end
    endtask

    task automatic random_step();
        logic [5:0] alu_fn[5];
        int         lo;
        int         hi;
        int         idx;
        int         code;
        logic [4:0] r;
        alu_fn = '{msie_pkg::FN_ADDU, msie_pkg::FN_SUBU, msie_pkg::FN_AND, msie_pkg::FN_OR,
                   msie_pkg::FN_SLT};
        if (pc_sh > tw_sh - 40) begin
            exec({msie_pkg::OPC_J, 26'($urandom_range(0, 30))});
            return;
        end
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4: exec(rtype(alu_fn[$urandom_range(0, 4)], 5'($urandom), 5'($urandom),
                                      free_reg()));
            5: exec(rtype(msie_pkg::FN_MULT, 5'($urandom), 5'($urandom), 5'($urandom)));
            6: exec(rtype(msie_pkg::FN_DIV, 5'($urandom),
                          $urandom_range(0, 1) ? msie_pkg::REG_GP : 5'd30, 5'($urandom)));
            7: exec(rtype($urandom_range(0, 1) ? msie_pkg::FN_MFHI : msie_pkg::FN_MFLO,
                          5'($urandom), 5'($urandom), free_reg()));
            8: exec(itype(msie_pkg::OPC_ADDIU, 5'($urandom), free_reg(), $urandom));
            9: begin
                idx = $urandom_range(0, (dw_sh < 256 ? dw_sh : 256) - 1);
                if (!written[idx]) begin
                    preload(8'(idx), $urandom);
                end
                exec(itype(msie_pkg::OPC_LW, 5'($urandom), free_reg(), idx));
            end
            10: exec(itype(msie_pkg::OPC_SW, 5'($urandom), 5'($urandom),
                           $urandom_range(0, (dw_sh < 256 ? dw_sh : 256) - 1)));
            11: begin
                r = 5'($urandom);
                case ($urandom_range(0, 2))
                    0: begin
                        lo = (pc_sh > 100) ? pc_sh - 100 : 0;
                        hi = (pc_sh + 100 < tw_sh - 2) ? pc_sh + 100 : tw_sh - 2;
                        exec(itype(msie_pkg::OPC_BEQ, r, r, $urandom_range(lo, hi) - pc_sh));
                    end
                    1: exec(itype(msie_pkg::OPC_BNE, r, r, $urandom));
                    default: exec(itype($urandom_range(0, 1) ? msie_pkg::OPC_BEQ
                                                             : msie_pkg::OPC_BNE,
                                        r, r + 5'd1, 1));
                endcase
            end
            12: exec({msie_pkg::OPC_J, 26'($urandom_range(0, tw_sh - 2))});
            13: begin
                case ($urandom_range(0, 2))
                    0: code = int'(msie_pkg::SYS_PRINT);
                    1: code = int'(msie_pkg::SYS_READ);
                    default: begin
                        do begin
                            code = $urandom_range(0, 40) - 20;
                        end while (code == int'(msie_pkg::SYS_PRINT)
                                   || code == int'(msie_pkg::SYS_READ)
                                   || code == int'(msie_pkg::SYS_EXIT));
                    end
                endcase
                exec(itype(msie_pkg::OPC_ADDIU, 5'd0, msie_pkg::REG_V0, code));
                exec(rtype(msie_pkg::FN_SYSCALL, 5'($urandom), 5'($urandom), 5'($urandom)));
            end
            default: preload(8'($urandom), $urandom);
        endcase
    endtask

    initial begin
        int per_phase;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_write(msie_tb_pkg::ADDR_TEXT_WORDS, 32'd1024);
        apb_write(msie_tb_pkg::ADDR_DATA_WORDS, 32'd256);

        preload(8'd0, 32'h8000_0000);
        preload(8'd1, 32'hffff_ffff);
        preload(8'd255, 32'h7fff_ffff);
        exec(itype(msie_pkg::OPC_LW, 5'd0, 5'd5, 0));
        exec(itype(msie_pkg::OPC_LW, 5'd31, 5'd30, 1));
        exec(itype(msie_pkg::OPC_LW, 5'd0, 5'd6, 255));
        exec(rtype(msie_pkg::FN_ADDU, 5'd5, 5'd6, 5'd7));
        exec(rtype(msie_pkg::FN_SUBU, 5'd5, 5'd6, 5'd8));
        exec(rtype(msie_pkg::FN_AND, 5'd5, 5'd30, 5'd9));
        exec(rtype(msie_pkg::FN_OR, 5'd5, 5'd6, 5'd10));
        exec(rtype(msie_pkg::FN_SLT, 5'd5, 5'd6, 5'd11));
        exec(rtype(msie_pkg::FN_SLT, 5'd6, 5'd5, 5'd12));
        exec(rtype(msie_pkg::FN_MULT, 5'd5, 5'd5, 5'd0));
        exec(rtype(msie_pkg::FN_MFHI, 5'd0, 5'd0, 5'd13));
        exec(rtype(msie_pkg::FN_DIV, 5'd5, 5'd30, 5'd0));
        exec(rtype(msie_pkg::FN_MFLO, 5'd0, 5'd0, 5'd14));
        exec(rtype(msie_pkg::FN_MFHI, 5'd0, 5'd0, 5'd15));
        exec(rtype(msie_pkg::FN_DIV, 5'd6, msie_pkg::REG_GP, 5'd0));
        exec(itype(msie_pkg::OPC_ADDIU, 5'd6, 5'd0, 5));
        exec(itype(msie_pkg::OPC_ADDIU, 5'd0, 5'd4, -32768));
        exec(itype(msie_pkg::OPC_SW, 5'd0, 5'd4, 3));
        exec(itype(msie_pkg::OPC_LW, 5'd0, 5'd17, 3));
        exec(itype(msie_pkg::OPC_ADDIU, 5'd0, msie_pkg::REG_V0, int'(msie_pkg::SYS_PRINT)));
        exec(rtype(msie_pkg::FN_SYSCALL, 5'd0, 5'd0, 5'd0));
        exec(itype(msie_pkg::OPC_ADDIU, 5'd0, msie_pkg::REG_V0, int'(msie_pkg::SYS_READ)));
        exec(rtype(msie_pkg::FN_SYSCALL, 5'd0, 5'd0, 5'd0), 32'h8000_0001);
        exec(itype(msie_pkg::OPC_BEQ, 5'd0, 5'd0, 3));
        exec(itype(msie_pkg::OPC_BNE, 5'd5, 5'd6, 1));

        for (int phase = 0; phase < 8; phase++) begin
            idle_pct = (phase % 4 == 1) ? 51 : (phase % 4 == 3) ? 14 : 0;
            stall_pct = (phase % 4 == 2) ? 51 : (phase % 4 == 3) ? 14 : 0;
            if (phase > 0) begin
                exec({msie_pkg::OPC_J, 26'd0});
                wait_idle();
                case (phase % 4)
                    0: begin
                        apb_write(msie_tb_pkg::ADDR_TEXT_WORDS, 32'd0);
                        apb_write(msie_tb_pkg::ADDR_TEXT_WORDS, 32'd1024);
                        apb_write(msie_tb_pkg::ADDR_DATA_WORDS, 32'd0);
                        apb_write(msie_tb_pkg::ADDR_DATA_WORDS, 32'd256);
                    end
                    1: begin
                        apb_write(msie_tb_pkg::ADDR_TEXT_WORDS, $urandom_range(200, 1023));
                        apb_write(msie_tb_pkg::ADDR_DATA_WORDS, 32'd1);
                    end
                    2: begin
                        apb_write(msie_tb_pkg::ADDR_TEXT_WORDS, 32'd1023);
                        apb_write(msie_tb_pkg::ADDR_DATA_WORDS, $urandom_range(2, 255));
                    end
                    default: begin
                        apb_write(msie_tb_pkg::ADDR_TEXT_WORDS, 32'd200);
                        apb_write(msie_tb_pkg::ADDR_DATA_WORDS, 32'd256);
                    end
                endcase
            end
            per_phase = n_items + 66;
            while (n_items < per_phase) begin
                random_step();
            end
        end

        idle_pct = 14;
        stall_pct = 14;
        scenario = $urandom_range(0, 7);
        case (scenario)
            0: exec({OPC_UNUSED, 26'($urandom)});
            1: exec(itype(msie_pkg::OPC_LW, 5'd0, 5'd5, -1));
            2: exec(rtype(msie_pkg::FN_DIV, 5'd5, 5'd0, 5'd0));
            3: begin
                exec(itype(msie_pkg::OPC_ADDIU, 5'd0, msie_pkg::REG_V0,
                           int'(msie_pkg::SYS_EXIT)));
                exec(rtype(msie_pkg::FN_SYSCALL, 5'd0, 5'd0, 5'd0));
            end
            4: begin
                exec({msie_pkg::OPC_J, 26'(tw_sh - 2)});
                exec(itype(msie_pkg::OPC_ADDIU, 5'd0, msie_pkg::REG_V0,
                           int'(msie_pkg::SYS_PRINT)));
                exec(rtype(msie_pkg::FN_SYSCALL, 5'd0, 5'd0, 5'd0));
            end
            5: exec({msie_pkg::OPC_J, 26'(tw_sh)});
            6: exec(itype(msie_pkg::OPC_BEQ, 5'd0, 5'd0, -pc_sh - 1));
            default: begin
                wait_idle();
                apb_write(msie_tb_pkg::ADDR_TEXT_WORDS, 32'd0);
                exec(rtype(msie_pkg::FN_ADDU, 5'd1, 5'd1, 5'd1));
            end
        endcase
        exec($urandom);
        exec(rtype(msie_pkg::FN_ADDU, 5'd1, 5'd2, 5'd3));
        preload(8'($urandom), $urandom);
        exec($urandom);
        preload(8'($urandom), $urandom);
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Checked %0d results from %0d transactions (%0d preloads) under four pacing modes,",
                 checked, n_items, n_preloads);
        $display("closing with halt scenario %0d and the halted responses after it.", scenario);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
